@@ rtl/core/irbs_pkg.sv @@
// ----------------------------------------------------------------------------
// irbs_pkg
// Shared types and constants for the index range bounding sphere block.
// ----------------------------------------------------------------------------
`default_nettype none

package irbs_pkg;

    // default configuration of the store and coordinate format
    localparam int IRBS_VERTEX_DEPTH = 4096;
    localparam int IRBS_COORD_WIDTH  = 24;

    // fixed field widths
    localparam int SLOT_W  = 12;
    localparam int COUNT_W = 13;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ACCUM = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQUARE,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_FINISH
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic store_wr;
        logic acc_read;
        logic acc_update;
        logic sq_start;
        logic sq_step;
        logic root_start;
        logic root_step;
        logic out_load;
        logic bounds_clear;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sq_done;
        logic root_done;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/index_range_bounding_sphere_top.sv @@
// ----------------------------------------------------------------------------
// index_range_bounding_sphere_top - bounding sphere of a streamed index range
// Load word: written to the store. Accumulate word: store read, then bound update.
// Last accumulate word: squaring over x, y, z, COORD_WIDTH+1 root steps, then
// result load, held off while an untaken result waits; input reopens in the
// cycle after the load. Sync active-low reset; store not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module index_range_bounding_sphere_top
    import irbs_pkg::*;
#(
    parameter int VERTEX_DEPTH = IRBS_VERTEX_DEPTH,
    parameter int COORD_WIDTH  = IRBS_COORD_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // vertex count register write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [COUNT_W-1:0]            cfg_vertex_count,
    // command words
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_command,
    input  wire logic [SLOT_W-1:0]             s_vertex_slot,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_z,
    input  wire logic                          s_last,
    // result words
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0]      m_center_x,
    output logic signed [COORD_WIDTH-1:0]      m_center_y,
    output logic signed [COORD_WIDTH-1:0]      m_center_z,
    output logic [COORD_WIDTH-1:0]             m_radius,
    output logic                               m_empty_res
);

    // The controller takes one word at a time. A load word writes the store
    // directly; an accumulate word reads the store into a register, and the
    // following cycle folds that vertex into the running min/max (skipped
    // when the index is past the vertex count or the store).
    // On a last accumulate word the controller runs the shared squarer over x, y, z,
    // then the bit-serial root of sum/4, which is floor(sqrt(sum)/2).
    // The result sits in an output register; the next range can start while
    // it waits, and only a second result stalls until the first is taken.

    dp_cmd_t cmd;
    dp_sts_t sts;

    irbs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_last    (s_last),
        .cmd       (cmd),
        .sts       (sts)
    );

    irbs_dpath #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_vertex_count (cfg_vertex_count),
        .s_vertex_slot    (s_vertex_slot),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_center_x       (m_center_x),
        .m_center_y       (m_center_y),
        .m_center_z       (m_center_z),
        .m_radius         (m_radius),
        .m_empty_res      (m_empty_res)
    );

endmodule

`default_nettype wire

@@ rtl/core/irbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// irbs_ctrl
// Sequencer: load/accumulate handling, squaring, root and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module irbs_ctrl
    import irbs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire logic    s_command,
    input  wire logic    s_last,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    ctrl_state_t state_reg, state_next;
    logic        last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == CMD_LOAD) begin
                        cmd.store_wr = 1'b1;
                    end else begin
                        cmd.acc_read = 1'b1;
                        last_next    = s_last;
                        state_next   = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                cmd.acc_update = 1'b1;
                if (last_reg) begin
                    cmd.sq_start = 1'b1;
                    state_next   = ST_SQUARE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQUARE: begin
                cmd.sq_step = 1'b1;
                if (sts.sq_done) begin
                    state_next = ST_ROOT_INIT;
                end
            end
            ST_ROOT_INIT: begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (sts.root_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.bounds_clear = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_accum_to_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_ACCUM) |=> state_reg == ST_ACC)
        else $error("accumulate word did not enter update state");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken result");

    a_root_init: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROOT_INIT |=> state_reg == ST_ROOT)
        else $error("root init not followed by root");

    a_square_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQUARE && !sts.sq_done) |=> state_reg == ST_SQUARE)
        else $error("squaring left early");
`endif

endmodule

`default_nettype wire

@@ rtl/core/irbs_dpath.sv @@
// ----------------------------------------------------------------------------
// irbs_dpath
// Vertex store, bound registers, shared squarer, bit-serial root, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module irbs_dpath
    import irbs_pkg::*;
#(
    parameter int VERTEX_DEPTH = IRBS_VERTEX_DEPTH,
    parameter int COORD_WIDTH  = IRBS_COORD_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [COUNT_W-1:0]            cfg_vertex_count,
    input  wire logic [SLOT_W-1:0]             s_vertex_slot,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_pos_z,
    input  wire dp_cmd_t                       cmd,
    output dp_sts_t                            sts,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0]      m_center_x,
    output logic signed [COORD_WIDTH-1:0]      m_center_y,
    output logic signed [COORD_WIDTH-1:0]      m_center_z,
    output logic [COORD_WIDTH-1:0]             m_radius,
    output logic                               m_empty_res
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int EW   = CW + 1;        // extent width
    localparam int PW   = 2 * EW;        // square width, also radicand width
    localparam int SW   = PW + 2;        // sum of three squares
    localparam int RW   = EW;            // root width
    localparam int CNTW = $clog2(RW + 1);

    // ---------------- config ----------------
    logic [COUNT_W-1:0] vertex_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            vertex_count_reg <= cfg_vertex_count;
        end
    end

    // ---------------- vertex store ----------------
    logic [3*CW-1:0] mem [VERTEX_DEPTH];
    logic [3*CW-1:0] rd_data_reg;
    logic            hit_reg;
    logic [31:0]     slot_ext;
    logic [AW-1:0]   addr;
    logic            in_store;
    logic            in_count;

    assign slot_ext = 32'(s_vertex_slot);
    assign addr     = slot_ext[AW-1:0];
    assign in_store = slot_ext < 32'(VERTEX_DEPTH);
    assign in_count = {1'b0, s_vertex_slot} < vertex_count_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store_wr && in_store) begin
            mem[addr] <= {s_pos_z, s_pos_y, s_pos_x};
        end
        if (cmd.acc_read) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (cmd.acc_read) begin
            hit_reg <= in_store && in_count;
        end
    end

    // ---------------- bounds ----------------
    logic signed [CW-1:0] vtx      [3];
    logic signed [CW-1:0] low_reg  [3];
    logic signed [CW-1:0] high_reg [3];
    logic                 seen_any_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            vtx[a] = rd_data_reg[a*CW +: CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.bounds_clear) begin
            for (int a = 0; a < 3; a++) begin
                low_reg[a]  <= '0;
                high_reg[a] <= '0;
            end
            seen_any_reg <= 1'b0;
        end else if (cmd.acc_update && hit_reg) begin
            for (int a = 0; a < 3; a++) begin
                if (!seen_any_reg || vtx[a] < low_reg[a]) begin
                    low_reg[a] <= vtx[a];
                end
                if (!seen_any_reg || vtx[a] > high_reg[a]) begin
                    high_reg[a] <= vtx[a];
                end
            end
            seen_any_reg <= 1'b1;
        end
    end

    // ---------------- sum of squared extents ----------------
    // one axis per cycle through one multiplier, product registered
    logic [1:0]    sq_cnt_reg;
    logic [PW-1:0] prod_reg;
    logic [SW-1:0] sum_reg;
    logic [EW-1:0] extent;
    logic [1:0]    axis;

    always_comb begin
        case (sq_cnt_reg)
            2'd0:    axis = 2'd0;
            2'd1:    axis = 2'd1;
            default: axis = 2'd2;
        endcase
        extent = EW'($signed({high_reg[axis][CW-1], high_reg[axis]})
                   - $signed({low_reg[axis][CW-1], low_reg[axis]}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_cnt_reg <= '0;
        end else if (cmd.sq_start) begin
            sq_cnt_reg <= '0;
        end else if (cmd.sq_step) begin
            sq_cnt_reg <= sq_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sq_start) begin
            sum_reg <= '0;
        end else if (cmd.sq_step) begin
            if (sq_cnt_reg != 2'd3) begin
                prod_reg <= extent * extent;
            end
            if (sq_cnt_reg != 2'd0) begin
                sum_reg <= sum_reg + SW'(prod_reg);
            end
        end
    end

    // ---------------- integer square root of sum/4 ----------------
    // restoring, one result bit per cycle
    logic [PW-1:0]   rad_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CNTW-1:0] root_cnt_reg;
    logic [RW+1:0]   shifted;
    logic [RW+1:0]   trial;
    logic            fits;

    assign shifted = {rem_reg[RW-1:0], rad_reg[PW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign fits    = shifted >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_cnt_reg <= '0;
        end else if (cmd.root_start) begin
            root_cnt_reg <= '0;
        end else if (cmd.root_step) begin
            root_cnt_reg <= root_cnt_reg + CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.root_start) begin
            rad_reg  <= sum_reg[SW-1:2];
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg  <= {rad_reg[PW-3:0], 2'b00};
            rem_reg  <= fits ? (shifted - trial) : shifted;
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

    // ---------------- result ----------------
    logic signed [CW:0] csum [3];
    logic               m_valid_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            csum[a] = $signed({low_reg[a][CW-1], low_reg[a]})
                    + $signed({high_reg[a][CW-1], high_reg[a]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (seen_any_reg) begin
                m_center_x  <= csum[0][CW:1];
                m_center_y  <= csum[1][CW:1];
                m_center_z  <= csum[2][CW:1];
                m_radius    <= root_reg[CW-1:0];
                m_empty_res <= 1'b0;
            end else begin
                m_center_x  <= '0;
                m_center_y  <= '0;
                m_center_z  <= '0;
                m_radius    <= '0;
                m_empty_res <= 1'b1;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign sts.sq_done   = sq_cnt_reg == 2'd3;
    assign sts.root_done = root_cnt_reg == CNTW'(RW - 1);
    assign sts.out_free  = !m_valid_reg || m_ready;

endmodule

`default_nettype wire
